/* sv/lzwbd_pkg.sv */
`timescale 1ns / 1ps
// package for the lzss window block decompressor
// holds payload structs, window geometry and state codes; no dependencies

package lzwbd_pkg;

  localparam int unsigned WindowSize  = 4096;
  localparam int unsigned WindowTail  = 256;
  localparam int unsigned WinDepth    = WindowSize + WindowTail;
  localparam int unsigned WinAw       = $clog2(WinDepth);
  localparam int unsigned MaxCopy     = 17;
  localparam logic [15:0] LimitReset  = 16'd32768;
  localparam logic [4:0]  LitBits     = 5'd9;
  localparam logic [4:0]  CopyBits    = 5'd17;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_END  = 3'd4;
  localparam logic [2:0] S_CLR  = 3'd5;

  typedef struct packed {
    logic [7:0] src_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        end_of_block;
    logic [15:0] produced_count;
  } out_t;

endpackage

/* sv/lzwbd_ram.sv */
`timescale 1ns / 1ps
// generic single-port ram with registered read
// no dependencies

module lzwbd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4352
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

/* sv/lzss_window_block_decompress_top.sv */
`timescale 1ns / 1ps
// top level of the lzss window block decompressor
// depends on lzwbd_pkg and lzwbd_ram

// One compressed byte per transaction; the block is busy until that byte is fully
// decoded. Each token is first decoded; a literal is then written and emitted, while
// a copy of n bytes first reads the n bytes from the window and then writes and emits
// them, all through the single window ram port. Output backpressure stalls the writes.
// After reset and after every last byte the window is rebuilt by a clearing pass over
// all 4352 entries, during which no transaction is taken.
module lzss_window_block_decompress_top
  import lzwbd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  logic [2:0]        state_q, state_d;
  logic [15:0]       limit_q;
  logic [23:0]       bstore_q, bstore_d;
  logic [4:0]        bcnt_q, bcnt_d;
  logic [WinAw-1:0]  pos_q, pos_d;
  logic [15:0]       ocnt_q, ocnt_d;
  logic              last_q, last_d;
  logic [11:0]       start_q, start_d;
  logic [4:0]        len_q, len_d;
  logic [4:0]        ri_q, ri_d;
  logic [4:0]        ci_q, ci_d;
  logic [4:0]        wi_q, wi_d;
  logic              rpend_q, rpend_d;
  logic [WinAw-1:0]  clr_q, clr_d;
  logic [7:0]        cbuf_q [MaxCopy];
  logic              hold_vld_q, hold_vld_d;
  logic [7:0]        hold_q, hold_d;
  logic              out_vld_q, out_vld_d;
  out_t              out_q, out_d;

  logic              ram_we;
  logic [WinAw-1:0]  ram_addr;
  logic [7:0]        ram_wdata, ram_rdata;
  logic              buf_we;
  logic [4:0]        buf_idx;
  logic [7:0]        buf_val;

  logic [23:0]       aligned;
  logic [4:0]        need, cnt_new;
  logic [15:0]       room;
  logic [4:0]        clen;
  logic              can_push;
  logic              accept;
  logic [WinAw-1:0]  pos_sum;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign can_push    = !out_vld_q || !out_stall_i;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign aligned = bstore_q << (5'd24 - bcnt_q);
  assign need    = aligned[23] ? CopyBits : LitBits;
  assign cnt_new = (bcnt_q > need) ? bcnt_q - need : 5'd0;
  assign room    = limit_q - ocnt_q;
  assign clen    = ({11'd0, 5'(aligned[10:7]) + 5'd2} > room) ? room[4:0]
                                                               : 5'(aligned[10:7]) + 5'd2;
  assign pos_sum = pos_q + WinAw'(len_q);

  lzwbd_ram #(
    .Width(8),
    .Depth(WinDepth)
  ) u_win (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    bstore_d   = bstore_q;
    bcnt_d     = bcnt_q;
    pos_d      = pos_q;
    ocnt_d     = ocnt_q;
    last_d     = last_q;
    start_d    = start_q;
    len_d      = len_q;
    ri_d       = ri_q;
    ci_d       = ci_q;
    wi_d       = wi_q;
    rpend_d    = 1'b0;
    clr_d      = clr_q;
    hold_vld_d = hold_vld_q;
    hold_d     = hold_q;
    out_vld_d  = out_vld_q && out_stall_i;
    out_d      = out_q;
    ram_we     = 1'b0;
    ram_addr   = pos_q;
    ram_wdata  = cbuf_q[wi_q];
    buf_we     = 1'b0;
    buf_idx    = ci_q;
    buf_val    = ram_rdata;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          last_d = in_data_i.last_byte;
          if (ocnt_q < limit_q && bcnt_q <= 5'd16) begin
            bstore_d = {bstore_q[15:0], in_data_i.src_byte};
            bcnt_d   = bcnt_q + 5'd8;
          end
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        if (bcnt_q == 5'd0) begin
          state_d = S_END;
        end else if (ocnt_q >= limit_q) begin
          bstore_d = '0;
          bcnt_d   = '0;
          state_d  = S_END;
        end else if (!last_q && bcnt_q < need) begin
          state_d = S_END;
        end else begin
          bcnt_d   = cnt_new;
          bstore_d = bstore_q & ((24'd1 << cnt_new) - 24'd1);
          wi_d     = '0;
          if (!aligned[23]) begin
            buf_we  = 1'b1;
            buf_idx = 5'd0;
            buf_val = aligned[22:15];
            len_d   = 5'd1;
            state_d = S_WR;
          end else begin
            start_d = aligned[22:11];
            len_d   = clen;
            ri_d    = '0;
            ci_d    = '0;
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        ram_addr = WinAw'(start_q) + WinAw'(ri_q);
        if (ri_q < len_q) begin
          rpend_d = 1'b1;
          ri_d    = ri_q + 5'd1;
        end
        if (rpend_q) begin
          buf_we = 1'b1;
          ci_d   = ci_q + 5'd1;
          if (ci_q + 5'd1 == len_q) begin
            state_d = S_WR;
          end
        end
      end
      S_WR: begin
        ram_addr = pos_q + WinAw'(wi_q);
        if (!hold_vld_q || can_push) begin
          if (hold_vld_q) begin
            out_vld_d = 1'b1;
            out_d     = '{out_byte: hold_q, byte_valid: 1'b1, end_of_block: 1'b0,
                          produced_count: 16'd0};
          end
          hold_vld_d = 1'b1;
          hold_d     = cbuf_q[wi_q];
          ram_we     = 1'b1;
          ocnt_d     = ocnt_q + 16'd1;
          wi_d       = wi_q + 5'd1;
          if (wi_q + 5'd1 == len_q) begin
            pos_d   = (pos_sum >= WinAw'(WindowSize)) ? '0 : pos_sum;
            state_d = S_DEC;
          end
        end
      end
      S_END: begin
        if (can_push) begin
          if (last_q) begin
            out_vld_d  = 1'b1;
            out_d      = '{out_byte: hold_vld_q ? hold_q : 8'd0, byte_valid: hold_vld_q,
                           end_of_block: 1'b1, produced_count: ocnt_q};
            hold_vld_d = 1'b0;
            bstore_d   = '0;
            bcnt_d     = '0;
            pos_d      = '0;
            ocnt_d     = '0;
            clr_d      = '0;
            state_d    = S_CLR;
          end else begin
            if (hold_vld_q) begin
              out_vld_d = 1'b1;
              out_d     = '{out_byte: hold_q, byte_valid: 1'b1, end_of_block: 1'b0,
                            produced_count: 16'd0};
            end
            hold_vld_d = 1'b0;
            state_d    = S_IDLE;
          end
        end
      end
      S_CLR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = (clr_q < WinAw'(WindowSize)) ? clr_q[11:4] : 8'd0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == WinAw'(WinDepth - 1)) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLR;
        clr_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      limit_q    <= LimitReset;
      bstore_q   <= '0;
      bcnt_q     <= '0;
      pos_q      <= '0;
      ocnt_q     <= '0;
      last_q     <= 1'b0;
      ri_q       <= '0;
      ci_q       <= '0;
      wi_q       <= '0;
      len_q      <= '0;
      rpend_q    <= 1'b0;
      clr_q      <= '0;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      bstore_q   <= bstore_d;
      bcnt_q     <= bcnt_d;
      pos_q      <= pos_d;
      ocnt_q     <= ocnt_d;
      last_q     <= last_d;
      ri_q       <= ri_d;
      ci_q       <= ci_d;
      wi_q       <= wi_d;
      len_q      <= len_d;
      rpend_q    <= rpend_d;
      clr_q      <= clr_d;
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    hold_q  <= hold_d;
    out_q   <= out_d;
    if (buf_we) begin
      cbuf_q[buf_idx] <= buf_val;
    end
  end

endmodule

/* bench/lzwbd_decode_checker.sv */
`timescale 1ns / 1ps
// checker for the lzss window block decompressor: watches both channels and the limit port
// decodes every accepted compressed byte itself and compares the emitted bytes; uses lzwbd_pkg

module lzwbd_decode_checker
  import lzwbd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_t        out_data_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output int          fail_count_o,
  output int          pending_o
);

  logic [7:0]  hist [WinDepth];
  int unsigned bit_store;
  int unsigned bit_cnt;
  int unsigned wr_pos;
  int unsigned byte_cnt;
  int unsigned out_limit;
  out_t        expected_bytes [$];

  function automatic int unsigned low_mask(int unsigned k);
    return (k >= 32) ? 32'hffffffff : ((32'd1 << k) - 1);
  endfunction

  function automatic int unsigned peek_bits(int unsigned k);
    if (bit_cnt >= k) return (bit_store >> (bit_cnt - k)) & low_mask(k);
    return (bit_store << (k - bit_cnt)) & low_mask(k);
  endfunction

  task automatic clear_block();
    for (int a = 0; a < WinDepth; a++) begin
      hist[a] = (a < WindowSize) ? 8'((a >> 4) & 8'hff) : 8'h00;
    end
    bit_store = 0;
    bit_cnt   = 0;
    wr_pos    = 0;
    byte_cnt  = 0;
  endtask

  task automatic emit_byte(logic [7:0] b);
    out_t r;
    r = '{out_byte: b, byte_valid: 1'b1, end_of_block: 1'b0, produced_count: 16'd0};
    expected_bytes.insert(expected_bytes.size(), r);
    byte_cnt = (byte_cnt + 1) & 32'hffff;
  endtask

  task automatic decode_byte(in_t d);
    int unsigned flag, need, v, start, len, room, n;
    logic [7:0]  copy_buf [MaxCopy];
    out_t        r;
    n = 0;
    if (byte_cnt < out_limit && bit_cnt <= 16) begin
      bit_store = ((bit_store << 8) | d.src_byte) & 32'hffffff;
      bit_cnt  += 8;
    end
    while (bit_cnt > 0) begin
      if (byte_cnt >= out_limit) begin
        bit_store = 0;
        bit_cnt   = 0;
        break;
      end
      flag = peek_bits(1);
      need = flag ? CopyBits : LitBits;
      if (!d.last_byte && bit_cnt < need) break;
      v         = peek_bits(need);
      bit_cnt   = (bit_cnt > need) ? bit_cnt - need : 0;
      bit_store = bit_store & low_mask(bit_cnt);
      if (flag == 0) begin
        emit_byte(v[7:0]);
        n++;
        if (wr_pos < WinDepth) hist[wr_pos] = v[7:0];
        wr_pos++;
      end else begin
        start = (v >> 4) & 32'hfff;
        len   = (v & 32'h0f) + 2;
        room  = out_limit - byte_cnt;
        if (len > room) len = room;
        for (int i = 0; i < len; i++) begin
          copy_buf[i] = (start + i < WinDepth) ? hist[start + i] : 8'h00;
        end
        for (int i = 0; i < len; i++) begin
          emit_byte(copy_buf[i]);
          n++;
          if (wr_pos + i < WinDepth) hist[wr_pos + i] = copy_buf[i];
        end
        wr_pos += len;
      end
      if (wr_pos >= WindowSize) wr_pos = 0;
    end
    if (d.last_byte) begin
      if (n == 0) begin
        r = '{out_byte: 8'h00, byte_valid: 1'b0, end_of_block: 1'b0, produced_count: 16'd0};
      end else begin
        r = expected_bytes.pop_back();
      end
      r.end_of_block   = 1'b1;
      r.produced_count = 16'(byte_cnt);
      expected_bytes.insert(expected_bytes.size(), r);
      clear_block();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t e;
    if (!rst_ni) begin
      out_limit = LimitReset;
      clear_block();
      expected_bytes.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) out_limit = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) decode_byte(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected output transaction, actual %p", $time, out_data_i);
          fail_count_o++;
        end else begin
          e = expected_bytes.pop_front();
          if (out_data_i.out_byte !== e.out_byte) begin
            $display("%0t: out_byte expected %h actual %h", $time, e.out_byte,
                     out_data_i.out_byte);
            fail_count_o++;
          end
          if (out_data_i.byte_valid !== e.byte_valid) begin
            $display("%0t: byte_valid expected %b actual %b", $time, e.byte_valid,
                     out_data_i.byte_valid);
            fail_count_o++;
          end
          if (out_data_i.end_of_block !== e.end_of_block) begin
            $display("%0t: end_of_block expected %b actual %b", $time, e.end_of_block,
                     out_data_i.end_of_block);
            fail_count_o++;
          end
          if (out_data_i.produced_count !== e.produced_count) begin
            $display("%0t: produced_count expected %0d actual %0d", $time,
                     e.produced_count, out_data_i.produced_count);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = expected_bytes.size();
  end

endmodule

/* bench/lzss_window_block_decompress_top_tb.sv */
`timescale 1ns / 1ps
// testbench top for the lzss window block decompressor: builds compressed blocks and limits
// depends on lzwbd_pkg, lzss_window_block_decompress_top and lzwbd_decode_checker

module lzss_window_block_decompress_top_tb;
  import lzwbd_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_t        out_data_o;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  int          fail_count;
  int          pending;
  int          idle_pct = 20;
  bit          token_bits [$];

  lzss_window_block_decompress_top DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o, .cfg_we_i, .cfg_wdata_i
  );

  lzwbd_decode_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .cfg_we_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < idle_pct);
  end

  initial begin
    #40ms;
    $display("** lzss_window_block_decompress_top: FAILED **");
    $finish;
  end

  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{src_byte: b, last_byte: last};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic add_literal(logic [7:0] b);
    token_bits.insert(token_bits.size(), 1'b0);
    for (int i = 7; i >= 0; i--) token_bits.insert(token_bits.size(), b[i]);
  endtask

  task automatic add_copy(logic [11:0] start, logic [3:0] code);
    token_bits.insert(token_bits.size(), 1'b1);
    for (int i = 11; i >= 0; i--) token_bits.insert(token_bits.size(), start[i]);
    for (int i = 3; i >= 0; i--) token_bits.insert(token_bits.size(), code[i]);
  endtask

  // packs the token bits msb first, random fill, optionally cut short
  task automatic send_block(bit cut);
    int         nbytes;
    logic [7:0] b;
    nbytes = (token_bits.size() + 7) / 8;
    if (nbytes == 0) nbytes = 1;
    if (cut && nbytes > 1) nbytes = $urandom_range(nbytes - 1, 1);
    for (int k = 0; k < nbytes; k++) begin
      b = 8'($urandom);
      for (int i = 0; i < 8; i++) begin
        if (k * 8 + i < token_bits.size()) b[7 - i] = token_bits[k * 8 + i];
      end
      send_byte(b, k == nbytes - 1);
    end
    token_bits.delete();
  endtask

  task automatic random_blocks(int items);
    int   sent;
    int   ntok;
    logic [11:0] start;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(9) == 0) begin
        ntok = $urandom_range(6, 1);
        for (int i = 0; i < ntok; i++) send_byte(8'($urandom), i == ntok - 1);
        sent += ntok;
      end else begin
        ntok = $urandom_range(8, 1);
        for (int i = 0; i < ntok; i++) begin
          if ($urandom_range(1)) begin
            add_literal(8'($urandom));
          end else begin
            start = ($urandom_range(3) == 0) ? 12'($urandom_range(4095, 4080))
                                              : 12'($urandom);
            add_copy(start, 4'($urandom));
          end
        end
        sent += (token_bits.size() + 7) / 8;
        send_block($urandom_range(7) == 0);
      end
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4500) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [15:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= 16'($urandom);
    @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] limits [6];
    limits = '{16'd0, 16'd1, 16'hffff, 16'd7, 16'd300, 16'd32768};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (4500) @(posedge clk_i);

    add_literal(8'h00);
    add_literal(8'hff);
    add_copy(12'h000, 4'h0);
    add_copy(12'hfff, 4'hf);
    add_copy(12'hff8, 4'h7);
    add_copy(12'h002, 4'hf);
    send_block(1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);

    // long well-formed block that carries the write pointer past the window end
    idle_pct = 0;
    for (int i = 0; i < 243; i++) add_copy(12'($urandom), 4'hf);
    send_block(1'b0);
    idle_pct = 20;

    random_blocks(20);
    foreach (limits[p]) begin
      drain();
      write_limit(limits[p]);
      if (limits[p] < 16'd8) begin
        add_literal(8'h5a);
        add_copy(12'h100, 4'hf);
        send_block(1'b0);
      end
      random_blocks(8);
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** lzss_window_block_decompress_top: PASSED **");
    end else begin
      $display("** lzss_window_block_decompress_top: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
sv/lzwbd_pkg.sv
sv/lzwbd_ram.sv
sv/lzss_window_block_decompress_top.sv
bench/lzwbd_decode_checker.sv
bench/lzss_window_block_decompress_top_tb.sv
